// File: design/knn_pkg.sv
// Shared types, constants and helpers for the k-nearest-neighbor vote block.
// Used by knn_front, knn_queue, knn_back and knn_top5_vote_classifier.
// No dependencies.
package knn_pkg;

  localparam int NEIGHBOURS = 5;
  localparam int DIM_PAIRS = 7;
  localparam int DIMS = 2 * DIM_PAIRS;
  localparam int GROUPS = (DIMS + 3) / 4;
  localparam int PACK_W = 256;

  localparam int SLOT_W = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
  localparam int CNT_W = ($clog2(NEIGHBOURS + 1) < 3) ? 3 : $clog2(NEIGHBOURS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int APPROVE_LIMIT = 3;
  localparam int FRAUD_MAX = 7;

  localparam logic [63:0] KEY_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] REG_QUERY_0_3 = 2'd0;
  localparam logic [1:0] REG_QUERY_4_7 = 2'd1;
  localparam logic [1:0] REG_QUERY_8_11 = 2'd2;
  localparam logic [1:0] REG_QUERY_12_13 = 2'd3;

  typedef struct packed {
    logic [63:0] key;
    logic        first;
    logic        last;
  } key_item_t;

  // 16-bit lane d of a packed set of dimensions, dim 0 in the low bits
  function automatic logic [15:0] lane(input logic [PACK_W-1:0] w, input int d);
    lane = w[d*16 +: 16];
  endfunction

endpackage

// File: design/knn_top5_vote_classifier.sv
// A query's result is registered after its last reference passes pipeline and queue.
// Throughput: one reference vector per cycle unless stalled; the 4-stage distance
// pipeline and five-slot update take an item every cycle, a 4-entry queue between.
// Reset (synchronous): query registers to zero, kept keys to all ones, all valids low.
// Top level of the k-nearest-neighbor vote block; depends on knn_pkg, knn_front,
// knn_queue and knn_back.
module knn_top5_vote_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] ref_dims_0_3,
  input  logic [63:0] ref_dims_4_7,
  input  logic [63:0] ref_dims_8_11,
  input  logic [31:0] ref_dims_12_13,
  input  logic [30:0] ref_id,
  input  logic        ref_is_fraud,
  input  logic        first_of_query,
  input  logic        last_of_query,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  fraud_tally,
  output logic        approved,
  output logic [31:0] kth_distance
);

  logic               fq_valid, fq_ready;
  knn_pkg::key_item_t fq_item;
  logic               qb_valid, qb_ready;
  knn_pkg::key_item_t qb_item;

  knn_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ref_dims_0_3  (ref_dims_0_3),
    .ref_dims_4_7  (ref_dims_4_7),
    .ref_dims_8_11 (ref_dims_8_11),
    .ref_dims_12_13(ref_dims_12_13),
    .ref_id        (ref_id),
    .ref_is_fraud  (ref_is_fraud),
    .first_of_query(first_of_query),
    .last_of_query (last_of_query),
    .out_valid     (fq_valid),
    .out_ready     (fq_ready),
    .out_item      (fq_item)
  );

  knn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fq_valid),
    .in_ready (fq_ready),
    .in_item  (fq_item),
    .out_valid(qb_valid),
    .out_ready(qb_ready),
    .out_item (qb_item)
  );

  knn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (qb_valid),
    .in_ready    (qb_ready),
    .in_item     (qb_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fraud_tally (fraud_tally),
    .approved    (approved),
    .kth_distance(kth_distance)
  );

endmodule

// File: design/knn_front.sv
// Front end: query registers and the pipelined squared-distance unit.
// Builds the 64-bit key per reference vector; depends on knn_pkg.
module knn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        ref_dims_0_3,
  input  logic [63:0]        ref_dims_4_7,
  input  logic [63:0]        ref_dims_8_11,
  input  logic [31:0]        ref_dims_12_13,
  input  logic [30:0]        ref_id,
  input  logic               ref_is_fraud,
  input  logic               first_of_query,
  input  logic               last_of_query,
  output logic               out_valid,
  input  logic               out_ready,
  output knn_pkg::key_item_t out_item
);

  logic [63:0] query_0_3;
  logic [63:0] query_4_7;
  logic [63:0] query_8_11;
  logic [31:0] query_12_13;

  logic [knn_pkg::PACK_W-1:0] ref_pack;
  logic [knn_pkg::PACK_W-1:0] query_pack;

  logic        adv;
  logic        v1, v2, v3, v4;
  logic [15:0] mag_in [knn_pkg::DIMS];
  logic [15:0] mag1 [knn_pkg::DIMS];
  logic [31:0] sq2 [knn_pkg::DIMS];
  logic [31:0] part_in [knn_pkg::GROUPS];
  logic [31:0] part3 [knn_pkg::GROUPS];
  logic [31:0] dist_sum;
  logic [31:0] meta1, meta2, meta3;
  logic        first1, first2, first3;
  logic        last1, last2, last3;
  knn_pkg::key_item_t item4;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_0_3 <= '0;
      query_4_7 <= '0;
      query_8_11 <= '0;
      query_12_13 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        knn_pkg::REG_QUERY_0_3: query_0_3 <= cfg_data;
        knn_pkg::REG_QUERY_4_7: query_4_7 <= cfg_data;
        knn_pkg::REG_QUERY_8_11: query_8_11 <= cfg_data;
        knn_pkg::REG_QUERY_12_13: query_12_13 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign ref_pack = {32'd0, ref_dims_12_13, ref_dims_8_11, ref_dims_4_7, ref_dims_0_3};
  assign query_pack = {32'd0, query_12_13, query_8_11, query_4_7, query_0_3};

  // whole pipeline holds only when the last stage cannot hand off
  assign adv = !v4 || out_ready;
  assign in_ready = adv;

  // lane magnitude of the wrapped 16-bit difference
  always_comb begin
    logic [15:0] diff;
    diff = '0;
    for (int d = 0; d < knn_pkg::DIMS; d++) begin
      diff = knn_pkg::lane(ref_pack, d) - knn_pkg::lane(query_pack, d);
      mag_in[d] = diff[15] ? (~diff + 16'd1) : diff;
    end
  end

  // groups of four squares
  always_comb begin
    logic [31:0] acc;
    acc = '0;
    for (int g = 0; g < knn_pkg::GROUPS; g++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < knn_pkg::DIMS) begin
          acc = acc + sq2[g*4+k];
        end
      end
      part_in[g] = acc;
    end
  end

  always_comb begin
    dist_sum = '0;
    for (int g = 0; g < knn_pkg::GROUPS; g++) begin
      dist_sum = dist_sum + part3[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < knn_pkg::DIMS; d++) begin
        mag1[d] <= mag_in[d];
        sq2[d] <= 32'(mag1[d]) * 32'(mag1[d]);
      end
      for (int g = 0; g < knn_pkg::GROUPS; g++) begin
        part3[g] <= part_in[g];
      end
      meta1 <= {ref_id, ref_is_fraud};
      first1 <= first_of_query;
      last1 <= last_of_query;
      meta2 <= meta1;
      first2 <= first1;
      last2 <= last1;
      meta3 <= meta2;
      first3 <= first2;
      last3 <= last2;
      item4.key <= {dist_sum, meta3};
      item4.first <= first3;
      item4.last <= last3;
    end
  end

  assign out_valid = v4;
  assign out_item = item4;

endmodule

// File: design/knn_queue.sv
// Short FIFO of keyed items between the distance front end and the top-k back end.
// Depends on knn_pkg for the item type and depth.
module knn_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  knn_pkg::key_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output knn_pkg::key_item_t out_item
);

  knn_pkg::key_item_t entries [knn_pkg::QUEUE_DEPTH];
  logic [knn_pkg::QPTR_W-1:0] wr_ptr;
  logic [knn_pkg::QPTR_W-1:0] rd_ptr;
  logic [knn_pkg::QCNT_W-1:0] count;
  logic push, pop;

  assign in_ready = (count != knn_pkg::QCNT_W'(knn_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item = entries[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

endmodule

// File: design/knn_back.sv
// Back end: keeps the smallest keys of the current query and registers the vote.
// Depends on knn_pkg.
module knn_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  knn_pkg::key_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         fraud_tally,
  output logic               approved,
  output logic [31:0]        kth_distance
);

  logic [63:0] keys [knn_pkg::NEIGHBOURS];
  logic [63:0] worst_key;
  logic [knn_pkg::SLOT_W-1:0] worst_slot;

  logic [63:0] keys_next [knn_pkg::NEIGHBOURS];
  logic [63:0] worst_key_next;
  logic [knn_pkg::SLOT_W-1:0] worst_slot_next;
  logic [63:0] base_wk;
  logic [knn_pkg::SLOT_W-1:0] base_ws;
  logic take;
  logic pop;
  logic [knn_pkg::CNT_W-1:0] cnt;
  logic [knn_pkg::NEIGHBOURS-1:0] occupied;

  // a last item needs the result register free
  assign in_ready = !in_item.last || !out_valid || out_ready;
  assign pop = in_valid && in_ready;

  always_comb begin
    base_wk = in_item.first ? knn_pkg::KEY_ALL_ONES : worst_key;
    base_ws = in_item.first ? '0 : worst_slot;
    take = (in_item.key < base_wk);
    for (int j = 0; j < knn_pkg::NEIGHBOURS; j++) begin
      keys_next[j] = in_item.first ? knn_pkg::KEY_ALL_ONES : keys[j];
      if (take && (knn_pkg::SLOT_W'(j) == base_ws)) keys_next[j] = in_item.key;
    end
    // first slot holding the largest key wins
    worst_key_next = keys_next[0];
    worst_slot_next = '0;
    for (int j = 1; j < knn_pkg::NEIGHBOURS; j++) begin
      if (keys_next[j] > worst_key_next) begin
        worst_key_next = keys_next[j];
        worst_slot_next = knn_pkg::SLOT_W'(j);
      end
    end
    cnt = '0;
    for (int j = 0; j < knn_pkg::NEIGHBOURS; j++) begin
      cnt = cnt + knn_pkg::CNT_W'(keys_next[j][0]);
    end
  end

  always_comb begin
    for (int j = 0; j < knn_pkg::NEIGHBOURS; j++) begin
      occupied[j] = (keys[j] != knn_pkg::KEY_ALL_ONES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < knn_pkg::NEIGHBOURS; j++) begin
        keys[j] <= knn_pkg::KEY_ALL_ONES;
      end
      worst_key <= knn_pkg::KEY_ALL_ONES;
      worst_slot <= '0;
    end else if (pop) begin
      for (int j = 0; j < knn_pkg::NEIGHBOURS; j++) begin
        keys[j] <= keys_next[j];
      end
      worst_key <= worst_key_next;
      worst_slot <= worst_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && in_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && in_item.last) begin
      fraud_tally <= (cnt > knn_pkg::CNT_W'(knn_pkg::FRAUD_MAX)) ?
                     3'(knn_pkg::FRAUD_MAX) : 3'(cnt);
      approved <= (cnt < knn_pkg::CNT_W'(knn_pkg::APPROVE_LIMIT));
      kth_distance <= worst_key_next[63:32];
    end
  end

  a_worst_tracks_slot: assert property (@(posedge clk) disable iff (rst)
    worst_key == keys[worst_slot])
    else $error("worst key does not match its slot");

  a_vote_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (approved == (fraud_tally < 3'(knn_pkg::APPROVE_LIMIT))))
    else $error("approval disagrees with fraud tally");

  a_clear_on_first: assert property (@(posedge clk) disable iff (rst)
    (pop && in_item.first) |=> ($countones(occupied) <= 1))
    else $error("kept keys not emptied at start of query");

endmodule
